// ===== src/infix_to_postfix_converter_assert.svh =====
// Assertion macros for the infix to postfix converter.
// Both macros sample on clk_i and are switched off while rst_ni is low.
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define I2P_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Implication within the same clock edge.
`define I2P_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/i2p_pkg.sv =====
// Package for the infix to postfix converter: item types, symbol constants
// and the operand and rank helpers. Depends on nothing.
`timescale 1ns / 1ps

package i2p_pkg;

  typedef logic [1:0] rank_t;

  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;

  localparam rank_t RankHigh = 2'd3;
  localparam rank_t RankMid  = 2'd2;
  localparam rank_t RankLow  = 2'd1;

  // Entries in the queue between the front and back parts (a power of two).
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] in_symbol;
    logic       ends_expression;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       run_last;
    logic       expression_done;
    logic       stack_overflow;
  } out_item_t;

  // A classified input item as it travels from the front to the back part.
  typedef struct packed {
    logic [7:0] sym;
    logic       operand;
    rank_t      rank;
    logic       last;
  } sym_item_t;

  function automatic logic is_operand(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic rank_t rank_of(input logic [7:0] c);
    rank_t r;
    case (c)
      ChStar, ChSlash: r = RankHigh;
      ChPlus, ChMinus: r = RankMid;
      default:         r = RankLow;
    endcase
    return r;
  endfunction

endpackage

// ===== src/i2p_front.sv =====
// Front part: takes input items and classifies them as operands or ranked
// operators for the queue. Depends on i2p_pkg.
`timescale 1ns / 1ps

module i2p_front (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  i2p_pkg::in_item_t   in_item_i,
  input  logic                full_i,
  output logic                push_o,
  output i2p_pkg::sym_item_t  item_o
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o.sym     = in_item_i.in_symbol;
    item_o.operand = i2p_pkg::is_operand(in_item_i.in_symbol);
    item_o.rank    = i2p_pkg::rank_of(in_item_i.in_symbol);
    item_o.last    = in_item_i.ends_expression;
  end

endmodule

// ===== src/i2p_queue.sv =====
// Small first-in first-out queue of classified items between the front and
// back parts. Depends on i2p_pkg.
`timescale 1ns / 1ps

module i2p_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  i2p_pkg::sym_item_t  item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output i2p_pkg::sym_item_t  item_o
);

  localparam int unsigned PtrW = (i2p_pkg::QueueDepth > 1) ? $clog2(i2p_pkg::QueueDepth) : 1;

  i2p_pkg::sym_item_t     slot_q [i2p_pkg::QueueDepth];
  logic [PtrW-1:0]        wptr_q, wptr_d;
  logic [PtrW-1:0]        rptr_q, rptr_d;
  logic [PtrW:0]          fill_q, fill_d;
  logic                   do_push, do_pop;

  assign full_o  = (fill_q == (PtrW+1)'(i2p_pkg::QueueDepth));
  assign valid_o = (fill_q != '0);
  assign item_o  = slot_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + PtrW'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + PtrW'(1) : rptr_q;
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

// ===== src/i2p_back.sv =====
// Back part: operator stack and sequencer that emits, pops and pushes one
// step per cycle (an emit waits for a free output) into a registered output stage. Depends on i2p_pkg.
`timescale 1ns / 1ps

module i2p_back #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  i2p_pkg::sym_item_t                  q_item_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output i2p_pkg::out_item_t                  out_item_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]    stack_count_o
);

  localparam int unsigned CntW     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW    = $clog2(STACK_DEPTH);
  localparam int unsigned MemDepth = 1 << AddrW;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StWork  = 3'b010,
    StFlush = 3'b100
  } state_e;

  state_e              state_q, state_d;
  i2p_pkg::sym_item_t  cur_q, cur_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [7:0]          top_q, top_d;
  logic [7:0]          below_q;
  logic [7:0]          stack_mem [MemDepth];

  logic                out_valid_q;
  i2p_pkg::out_item_t  out_q;
  i2p_pkg::out_item_t  emit_item;
  logic                emit, out_free;
  logic                do_push, do_pop;
  logic                cnt_nz, cnt_full, more_below;
  i2p_pkg::rank_t      top_rank, below_rank;
  logic [CntW-1:0]     wr_cnt, rd_cnt;
  logic [AddrW-1:0]    wr_addr, rd_addr;
  logic                wr_en;

  assign out_free   = !out_valid_q || out_ready_i;
  assign cnt_nz     = (cnt_q != '0);
  assign cnt_full   = (cnt_q == CntW'(STACK_DEPTH));
  assign more_below = (cnt_q > CntW'(1));
  assign top_rank   = i2p_pkg::rank_of(top_q);
  assign below_rank = i2p_pkg::rank_of(below_q);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    emit_item = '0;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          state_d = StWork;
        end
      end
      StWork: begin
        if (cur_q.operand) begin
          if (out_free) begin
            emit                      = 1'b1;
            emit_item.out_symbol      = cur_q.sym;
            emit_item.run_last        = !(cur_q.last && cnt_nz);
            emit_item.expression_done = cur_q.last && !cnt_nz;
            state_d = (cur_q.last && cnt_nz) ? StFlush : StIdle;
          end
        end else if (cnt_nz && (top_rank >= cur_q.rank)) begin
          if (out_free) begin
            emit                 = 1'b1;
            do_pop               = 1'b1;
            emit_item.out_symbol = top_q;
            // Final result when no further pop follows and no flush is due.
            emit_item.run_last   = !cur_q.last && !(more_below && (below_rank >= cur_q.rank));
          end
        end else if (!cnt_full) begin
          do_push = 1'b1;
          state_d = cur_q.last ? StFlush : StIdle;
        end else begin
          if (out_free) begin
            emit                     = 1'b1;
            emit_item.stack_overflow = 1'b1;
            emit_item.run_last       = !cur_q.last;
            state_d = cur_q.last ? StFlush : StIdle;
          end
        end
      end
      StFlush: begin
        if (out_free) begin
          emit                 = 1'b1;
          do_pop               = 1'b1;
          emit_item.out_symbol = top_q;
          if (!more_below) begin
            emit_item.run_last        = 1'b1;
            emit_item.expression_done = 1'b1;
            state_d                   = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // The top entry lives in top_q; the memory holds the entries beneath it,
  // and below_q always mirrors the entry directly under the top.
  always_comb begin
    cnt_d = cnt_q;
    top_d = top_q;
    if (do_pop) begin
      cnt_d = cnt_q - CntW'(1);
      top_d = below_q;
    end else if (do_push) begin
      cnt_d = cnt_q + CntW'(1);
      top_d = cur_q.sym;
    end
  end

  assign wr_en   = do_push && cnt_nz;
  assign wr_cnt  = cnt_q - CntW'(1);
  assign wr_addr = wr_cnt[AddrW-1:0];
  assign rd_cnt  = cnt_d - CntW'(2);
  assign rd_addr = rd_cnt[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= top_q;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      below_q <= top_q;
    end else begin
      below_q <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    top_q <= top_d;
    if (emit) begin
      out_q <= emit_item;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_item_o    = out_q;
  assign stack_count_o = cnt_q;

endmodule

// ===== src/infix_to_postfix_converter.sv =====
// Top level of the infix to postfix converter: front classifier, item queue
// and stack sequencer. Depends on i2p_pkg and the assertion macro header.
//
//  Channel  Signals                           Carries
//  input    in_valid_i, in_ready_o, in_item_i  infix character, end-of-expression mark
//  output   out_valid_o, out_ready_i, out_item_o  postfix character and flags
//
// The back part handles one item at a time: it loads the item, then
// emits an operand, or pops entries for an operator and then pushes it,
// and flushes the stack at the end of an expression. The stack moves one
// entry per cycle through its single-write memory port, pops waiting for a free output.
// Reset clears the stack count, the queue and the output stage; stack entries
// need no clearing since only entries below the count are ever used.
// The two-entry queue keeps taking items, until it is full, while the back part is stalled by
// the output, and the output register holds a result until it is taken.
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_assert.svh"

module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  i2p_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2p_pkg::out_item_t  out_item_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  // Classified items pass from the front part into the queue here.
  logic                q_full;
  logic                q_push;
  i2p_pkg::sym_item_t  front_item;

  // And from the queue into the back part here.
  logic                q_valid;
  logic                q_pop;
  i2p_pkg::sym_item_t  q_item;

  // Entries held on the operator stack, watched by the checks below.
  logic [CntW-1:0]     stack_count;

  i2p_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .item_o     (front_item)
  );

  i2p_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // The back part owns the stack; an operator pops while the top entry ranks
  // at least as high, then is pushed, or is replaced by an error result when
  // the stack is full.
  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item_o),
    .stack_count_o (stack_count)
  );

  // The stack count never runs past the stack's depth.
  `I2P_ASSERT_ALWAYS(a_count_bound, stack_count <= CntW'(STACK_DEPTH), "stack count overflow")

  // An error result carries no symbol and never closes an expression.
  `I2P_ASSERT_IMP(a_ovf_result, out_valid_o && out_item_o.stack_overflow, (out_item_o.out_symbol == 8'h00) && !out_item_o.expression_done, "bad error result")

  // The end of an expression is always the last result of its item.
  `I2P_ASSERT_IMP(a_done_last, out_valid_o && out_item_o.expression_done, out_item_o.run_last, "done without run_last")

endmodule
